// ===== sv/overspeed_supervisor_defines.svh =====
// ----------------------------------------------------------------------------
// overspeed_supervisor_defines
// Assertion macros for the overspeed supervisor; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef OVERSPEED_SUPERVISOR_DEFINES_SVH
`define OVERSPEED_SUPERVISOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OSV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OSV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define OSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/osv_pkg.sv =====
// ----------------------------------------------------------------------------
// osv_pkg
// Shared types, state codes and register map of the overspeed supervisor.
// ----------------------------------------------------------------------------
package osv_pkg;

  localparam int SECS_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0]            sup_state_t;
  typedef logic [SECS_W-1:0]     secs_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // supervision state codes
  localparam sup_state_t ST_WARN_LO  = 2'd0;
  localparam sup_state_t ST_NORMAL   = 2'd1;
  localparam sup_state_t ST_WARN_HI  = 2'd2;
  localparam sup_state_t ST_SHUTDOWN = 2'd3;

  // register map
  localparam cfg_idx_t REG_LOW_LIMIT      = 3'd0;
  localparam cfg_idx_t REG_HIGH_LIMIT     = 3'd1;
  localparam cfg_idx_t REG_SHUTDOWN_LIMIT = 3'd2;
  localparam cfg_idx_t REG_DEADBAND       = 3'd3;
  localparam cfg_idx_t REG_MAX_WARN_SECS  = 3'd4;

  // reset values
  localparam cfg_data_t RST_LOW_LIMIT      = 32'd68000;
  localparam cfg_data_t RST_HIGH_LIMIT     = 32'd72000;
  localparam cfg_data_t RST_SHUTDOWN_LIMIT = 32'd75000;
  localparam secs_t     RST_DEADBAND       = 16'd500;
  localparam secs_t     RST_MAX_WARN_SECS  = 16'd20;

  typedef struct packed {
    sup_state_t state;
    secs_t      seconds_left;
    logic       load_start;   // entering warn high: capture timestamp
  } decision_t;

endpackage

// ===== sv/osv_ifs.sv =====
// ----------------------------------------------------------------------------
// osv_ifs
// Valid/ready channels of the overspeed supervisor.
// ----------------------------------------------------------------------------
interface osv_sample_if #(
  parameter int TIME_WIDTH  = 32,
  parameter int SPEED_WIDTH = 20
);
  logic                   valid;
  logic                   ready;
  logic [TIME_WIDTH-1:0]  now_seconds;
  logic [SPEED_WIDTH-1:0] speed;

  modport source (output valid, output now_seconds, output speed, input ready);
  modport sink   (input valid, input now_seconds, input speed, output ready);
endinterface

interface osv_result_if import osv_pkg::*; ();
  logic       valid;
  logic       ready;
  sup_state_t supervision_state;
  secs_t      seconds_left;

  modport source (output valid, output supervision_state, output seconds_left,
                  input ready);
  modport sink   (input valid, input supervision_state, input seconds_left,
                  output ready);
endinterface

interface osv_cfg_if import osv_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/osv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// osv_cfg_regs
// Configuration register file; always ready, writes masked to field width.
// ----------------------------------------------------------------------------
module osv_cfg_regs import osv_pkg::*; #(
  parameter int SPEED_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  osv_cfg_if.sink                cfg,
  output logic [SPEED_WIDTH-1:0] low_limit,
  output logic [SPEED_WIDTH-1:0] high_limit,
  output logic [SPEED_WIDTH-1:0] trip_limit,
  output secs_t                  deadband,
  output secs_t                  max_warn_seconds
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit        <= RST_LOW_LIMIT[SPEED_WIDTH-1:0];
      high_limit       <= RST_HIGH_LIMIT[SPEED_WIDTH-1:0];
      trip_limit       <= RST_SHUTDOWN_LIMIT[SPEED_WIDTH-1:0];
      deadband         <= RST_DEADBAND;
      max_warn_seconds <= RST_MAX_WARN_SECS;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_LOW_LIMIT:      low_limit        <= cfg.data[SPEED_WIDTH-1:0];
        REG_HIGH_LIMIT:     high_limit       <= cfg.data[SPEED_WIDTH-1:0];
        REG_SHUTDOWN_LIMIT: trip_limit       <= cfg.data[SPEED_WIDTH-1:0];
        REG_DEADBAND:       deadband         <= cfg.data[SECS_W-1:0];
        REG_MAX_WARN_SECS:  max_warn_seconds <= cfg.data[SECS_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

// ===== sv/osv_classify.sv =====
// ----------------------------------------------------------------------------
// osv_classify
// Per-sample decision: hysteresis thresholds, shutdown check, warn timer.
// ----------------------------------------------------------------------------
module osv_classify import osv_pkg::*; #(
  parameter int SPEED_WIDTH = 20,
  parameter int TIME_WIDTH  = 32
) (
  input  logic [TIME_WIDTH-1:0]  now_seconds,
  input  logic [SPEED_WIDTH-1:0] speed,
  input  sup_state_t             prev_state,
  input  logic [TIME_WIDTH-1:0]  warn_start,
  input  logic [SPEED_WIDTH-1:0] low_limit,
  input  logic [SPEED_WIDTH-1:0] high_limit,
  input  logic [SPEED_WIDTH-1:0] trip_limit,
  input  secs_t                  deadband,
  input  secs_t                  max_warn_seconds,
  output decision_t              dec
);

  // signed threshold width: room for limit + deadband + 2 and for negatives
  localparam int THR_W = ((SPEED_WIDTH > SECS_W) ? SPEED_WIDTH : SECS_W) + 2;
  localparam int CMP_W = (TIME_WIDTH > SECS_W) ? TIME_WIDTH : SECS_W;
  localparam logic signed [THR_W-1:0] ONE = THR_W'(1);
  localparam logic signed [THR_W-1:0] TWO = THR_W'(2);

  logic signed [THR_W-1:0] spd_s, hi_s, lo_s, db_s, hi_thr, lo_thr;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic [CMP_W-1:0]        elapsed_ext, max_ext, left_full;
  logic                    in_warn_hi, in_warn_lo;

  assign in_warn_hi = (prev_state == ST_WARN_HI);
  assign in_warn_lo = (prev_state == ST_WARN_LO);

  assign spd_s = $signed(THR_W'(speed));
  assign hi_s  = $signed(THR_W'(high_limit));
  assign lo_s  = $signed(THR_W'(low_limit));
  assign db_s  = $signed(THR_W'(deadband));

  assign hi_thr = in_warn_hi ? (hi_s - db_s) : (hi_s - ONE);
  assign lo_thr = in_warn_lo ? (lo_s + db_s + TWO) : (lo_s + ONE);

  // wrapping time difference
  assign elapsed     = now_seconds - warn_start;
  assign elapsed_ext = CMP_W'(elapsed);
  assign max_ext     = CMP_W'(max_warn_seconds);
  assign left_full   = max_ext - elapsed_ext;

  always_comb begin
    dec.state        = ST_NORMAL;
    dec.seconds_left = '0;
    dec.load_start   = 1'b0;
    if (speed >= trip_limit) begin
      dec.state = ST_SHUTDOWN;
    end else if (spd_s >= hi_thr) begin
      if (in_warn_hi) begin
        if (elapsed_ext > max_ext) begin
          dec.state = ST_SHUTDOWN;
        end else begin
          dec.state        = ST_WARN_HI;
          dec.seconds_left = left_full[SECS_W-1:0];
        end
      end else begin
        dec.state        = ST_WARN_HI;
        dec.seconds_left = max_warn_seconds;
        dec.load_start   = 1'b1;
      end
    end else if (spd_s > lo_thr) begin
      dec.state = ST_NORMAL;
    end else begin
      dec.state = ST_WARN_LO;
    end
  end

endmodule

// ===== sv/overspeed_supervisor.sv =====
// ----------------------------------------------------------------------------
// overspeed_supervisor
// Speed supervision with hysteresis, immediate shutdown and a warn timer.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one word = {now_seconds, speed}. Accepted on an
//             edge with valid and ready high.
//   results : source channel, one word = {supervision_state, seconds_left}
//             per sample, in order.
//   cfg     : register writes {index, data}; always ready. Write only while
//             no sample is in flight.
// Path: a sample passes the input register, then the classify logic into
//   the result register.
// Throughput: one sample per cycle unless results.ready stalls the output
//   (previous state and warn start are updated in the same cycle the
//   classify logic reads them).
// Reset: state returns to normal, warn start to zero, registers to their
//   defaults, both pipeline stages empty.
// Stall: while results.ready is low the result word holds; one more sample
//   may sit in the input register, after which samples.ready drops.
// ----------------------------------------------------------------------------
`include "overspeed_supervisor_defines.svh"

module overspeed_supervisor import osv_pkg::*; #(
  parameter int SPEED_WIDTH = 20,
  parameter int TIME_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst,
  osv_sample_if.sink    samples,
  osv_result_if.source  results,
  osv_cfg_if.sink       cfg
);

  // configuration
  logic [SPEED_WIDTH-1:0] low_limit, high_limit, trip_limit;
  secs_t                  deadband, max_warn_seconds;

  osv_cfg_regs #(.SPEED_WIDTH(SPEED_WIDTH)) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .low_limit        (low_limit),
    .high_limit       (high_limit),
    .trip_limit       (trip_limit),
    .deadband         (deadband),
    .max_warn_seconds (max_warn_seconds)
  );

  // input register
  logic                   s1_valid;
  logic [TIME_WIDTH-1:0]  s1_now;
  logic [SPEED_WIDTH-1:0] s1_speed;

  // result register
  logic       out_valid;
  sup_state_t out_state;
  secs_t      out_left;

  // supervision state carried between samples
  sup_state_t            prev_state;
  logic [TIME_WIDTH-1:0] warn_start;

  decision_t dec;
  logic      advance;

  // stage 1 moves into the result register when that one is free or draining
  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;

  osv_classify #(.SPEED_WIDTH(SPEED_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_classify (
    .now_seconds      (s1_now),
    .speed            (s1_speed),
    .prev_state       (prev_state),
    .warn_start       (warn_start),
    .low_limit        (low_limit),
    .high_limit       (high_limit),
    .trip_limit       (trip_limit),
    .deadband         (deadband),
    .max_warn_seconds (max_warn_seconds),
    .dec              (dec)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_now   <= samples.now_seconds;
      s1_speed <= samples.speed;
    end
  end

  // result stage and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_state <= ST_NORMAL;
      warn_start <= '0;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        prev_state <= dec.state;
        if (dec.load_start) begin
          warn_start <= s1_now;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= dec.state;
      out_left  <= dec.seconds_left;
    end
  end

  assign results.valid             = out_valid;
  assign results.supervision_state = out_state;
  assign results.seconds_left      = out_left;

  // checks
  `OSV_ASSERT_NOW(a_left_zero, clk, rst, out_valid && (out_state != ST_WARN_HI), out_left == '0, "seconds_left nonzero outside warn high")
  `OSV_ASSERT_NEXT(a_prev_tracks, clk, rst, advance, prev_state == out_state, "stored state differs from delivered state")
  `OSV_ASSERT_NOW(a_backpressure, clk, rst, s1_valid && out_valid && !results.ready, !samples.ready, "sample accepted with both stages full")

endmodule
